@@ sv/imdp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imdp_pkg: shared types and constants of the interrupt mask/pending core
// Field widths, command codes, the decoded operation type and the payload
// structs that travel between the front end, the queue and the sequencer.
// ----------------------------------------------------------------------------
package imdp_pkg;

    // controller and source counts
    localparam int CONTROLLERS = 8;
    localparam int SOURCES     = 7;

    // field widths
    localparam int CMD_W   = 3;
    localparam int CTL_W   = 3;
    localparam int SRC_W   = 3;
    localparam int EV_W    = 7;
    localparam int IRQ_W   = 7;
    localparam int CTLP1_W = CTL_W + 1;

    // item queue between front end and sequencer
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    // mask of valid source bits
    localparam logic [EV_W-1:0] SRC_MASK = 7'h7F;

    // command codes on the request channel
    localparam logic [CMD_W-1:0] CMD_EVENT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

    // decoded operation
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_EVENT   = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_QUERY   = 3'd5
    } op_t;

    // request payload
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [CTL_W-1:0] controller;
        logic [SRC_W-1:0] source_index;
        logic [EV_W-1:0]  events;
    } request_t;

    // result payload
    typedef struct packed {
        logic             dispatch_valid;
        logic [SRC_W-1:0] dispatch_source;
        logic [IRQ_W-1:0] irq_number;
        logic             pending_bit;
        logic             nothing_pending;
        logic             last;
    } result_t;

    // classified item as queued for the sequencer
    typedef struct packed {
        op_t                op;
        logic [CTL_W-1:0]   ctl;
        logic [SOURCES-1:0] src_mask;
        logic [SOURCES-1:0] events;
    } item_t;

    // queue write side
    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    // queue read side
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage : imdp_pkg
`default_nettype wire

@@ sv/imdp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imdp_if: request and result channels
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface imdp_req_if import imdp_pkg::*;
();
    logic     valid;
    logic     ready;
    request_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : imdp_req_if

interface imdp_rsp_if import imdp_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : imdp_rsp_if
`default_nettype wire

@@ sv/imdp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imdp_front: request intake and classification
// Accepts request items while the queue has room, decodes the command,
// range-checks controller and source and pushes a classified item.
// ----------------------------------------------------------------------------
module imdp_front import imdp_pkg::*;
(
    imdp_req_if.sink request,
    input  logic     q_full,
    output push_t    push
);

    op_t                op;
    logic               ctl_ok;
    logic [SOURCES-1:0] src_mask;

    // controller range check
    assign ctl_ok = ({1'b0, request.data.controller} < CTLP1_W'(CONTROLLERS));

    // one-hot source select, zero when the index is out of range
    always_comb
    begin
        for (int j = 0; j < SOURCES; j++)
        begin
            src_mask[j] = (request.data.source_index == SRC_W'(j));
        end
    end

    // command decode
    always_comb
    begin
        case (request.data.cmd)
            CMD_EVENT:   op = OP_EVENT;
            CMD_ENABLE:  op = OP_ENABLE;
            CMD_DISABLE: op = OP_DISABLE;
            CMD_CLEAR:   op = OP_CLEAR;
            CMD_QUERY:   op = OP_QUERY;
            default:     op = OP_NONE;
        endcase
        if (!ctl_ok)
        begin
            op = OP_NONE;
        end
    end

    // handshake and queue write
    assign request.ready      = !q_full;
    assign push.valid         = request.valid && !q_full;
    assign push.item.op       = op;
    assign push.item.ctl      = request.data.controller;
    assign push.item.src_mask = src_mask;
    assign push.item.events   = request.data.events & SRC_MASK;

endmodule : imdp_front
`default_nettype wire

@@ sv/imdp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imdp_queue: short item queue
// Two-entry queue that decouples request intake from the dispatch sequencer.
// ----------------------------------------------------------------------------
module imdp_queue import imdp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    input  logic  pop,
    output logic  full,
    output head_t head
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule : imdp_queue
`default_nettype wire

@@ sv/imdp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imdp_back: mask state and dispatch sequencer
// Holds the disabled and pending masks, carries out mask commands and scans
// event words one source step at a time, feeding a result output register.
// ----------------------------------------------------------------------------
module imdp_back import imdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  head_t      head,
    output logic       pop,
    imdp_rsp_if.source result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } seq_state_t;

    logic [SOURCES-1:0] dis_reg  [CONTROLLERS];
    logic [SOURCES-1:0] pend_reg [CONTROLLERS];

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [CTL_W-1:0]   ctl_reg;
    logic [CTL_W-1:0]   ctl_next;
    logic [SOURCES-1:0] ev_reg;
    logic [SOURCES-1:0] ev_next;
    logic [SRC_W-1:0]   idx_reg;
    logic [SRC_W-1:0]   idx_next;
    logic               phase_reg;
    logic               phase_next;
    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               can_emit;
    logic               emit;
    result_t            emit_data;
    logic [CTL_W-1:0]   rd_ctl;
    logic [SOURCES-1:0] dis_rd;
    logic [SOURCES-1:0] pend_rd;
    logic [SOURCES-1:0] dis_new;
    logic [SOURCES-1:0] pend_new;
    logic               dis_wr;
    logic               pend_wr;
    logic [SOURCES-1:0] bit_sel;
    logic [SOURCES-1:0] above;
    logic               disp_any;
    logic               more;
    logic               d_bit;
    logic               p_bit;
    logic               r_bit;
    logic [CTLP1_W-1:0] ctl_p1;

    assign can_emit = !out_valid_reg || result.ready;

    // single mask read port: head item while idle, latched controller in a scan
    assign rd_ctl  = (state_reg == ST_SCAN) ? ctl_reg : head.item.ctl;
    assign dis_rd  = dis_reg[rd_ctl];
    assign pend_rd = pend_reg[rd_ctl];

    // current scan step
    assign d_bit  = dis_rd[idx_reg];
    assign p_bit  = pend_rd[idx_reg];
    assign r_bit  = ev_reg[idx_reg];
    assign ctl_p1 = {1'b0, ctl_reg} + CTLP1_W'(1);

    always_comb
    begin
        for (int j = 0; j < SOURCES; j++)
        begin
            bit_sel[j] = (idx_reg == SRC_W'(j));
            above[j]   = (SRC_W'(j) > idx_reg);
        end
    end

    // any dispatch in the whole scan, any dispatch in sources after this step
    assign disp_any = |((head.item.events | pend_rd) & ~dis_rd);
    assign more     = |((ev_reg | pend_rd) & ~dis_rd & above);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ctl_next   = ctl_reg;
        ev_next    = ev_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_data  = '0;
        dis_new    = dis_rd;
        pend_new   = pend_rd;
        dis_wr     = 1'b0;
        pend_wr    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid && can_emit)
                begin
                    pop            = 1'b1;
                    emit           = 1'b1;
                    emit_data.last = 1'b1;
                    case (head.item.op)
                        OP_EVENT:
                        begin
                            if (head.item.events == '0)
                            begin
                                emit_data.nothing_pending = 1'b1;
                            end
                            else if (!disp_any)
                            begin
                                // only disabled sources raised: all become pending
                                pend_new = pend_rd | head.item.events;
                                pend_wr  = 1'b1;
                            end
                            else
                            begin
                                emit       = 1'b0;
                                ctl_next   = head.item.ctl;
                                ev_next    = head.item.events;
                                idx_next   = '0;
                                phase_next = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        OP_ENABLE:
                        begin
                            dis_new = dis_rd & ~head.item.src_mask;
                            dis_wr  = 1'b1;
                        end
                        OP_DISABLE:
                        begin
                            dis_new = dis_rd | head.item.src_mask;
                            dis_wr  = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            pend_new = pend_rd & ~head.item.src_mask;
                            pend_wr  = 1'b1;
                        end
                        OP_QUERY:
                        begin
                            emit_data.pending_bit = |(pend_rd & head.item.src_mask);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!phase_reg)
                begin
                    // raised-bit step: pend if disabled, else dispatch
                    if (d_bit)
                    begin
                        pend_new   = pend_rd | (ev_reg & bit_sel);
                        pend_wr    = 1'b1;
                        phase_next = 1'b1;
                    end
                    else if (r_bit)
                    begin
                        if (can_emit)
                        begin
                            emit                      = 1'b1;
                            emit_data.dispatch_valid  = 1'b1;
                            emit_data.dispatch_source = idx_reg;
                            emit_data.irq_number      = {ctl_p1, idx_reg};
                            emit_data.last            = !p_bit && !more;
                            phase_next                = 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    // pending-bit step: dispatch and clear when enabled
                    if (!d_bit && p_bit)
                    begin
                        if (can_emit)
                        begin
                            emit                      = 1'b1;
                            emit_data.dispatch_valid  = 1'b1;
                            emit_data.dispatch_source = idx_reg;
                            emit_data.irq_number      = {ctl_p1, idx_reg};
                            emit_data.last            = !more;
                            pend_new                  = pend_rd & ~bit_sel;
                            pend_wr                   = 1'b1;
                            phase_next                = 1'b0;
                            if (idx_reg == SRC_W'(SOURCES - 1))
                            begin
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + SRC_W'(1);
                            end
                        end
                    end
                    else
                    begin
                        phase_next = 1'b0;
                        if (idx_reg == SRC_W'(SOURCES - 1))
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + SRC_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan payload and result register
    always_ff @(posedge clk)
    begin
        ctl_reg <= ctl_next;
        ev_reg  <= ev_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

    // mask state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CONTROLLERS; c++)
            begin
                dis_reg[c]  <= '0;
                pend_reg[c] <= '0;
            end
        end
        else
        begin
            if (dis_wr)
            begin
                dis_reg[rd_ctl] <= dis_new;
            end
            if (pend_wr)
            begin
                pend_reg[rd_ctl] <= pend_new;
            end
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule : imdp_back
`default_nettype wire

@@ sv/interrupt_mask_pending_dispatch_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_mask_pending_dispatch_core: interrupt mask/pending dispatch core
// Per-controller disabled and pending masks with an event scan that emits
// one result per dispatched source.
// ----------------------------------------------------------------------------
// Request items are decoded at the input and held in a two-entry queue, so
// the request side keeps flowing while the sequencer works, until the queue
// is full. Enable, disable, clear, query, empty event words and event words
// that dispatch nothing give a single result. An event word that dispatches
// starts a scan of source steps (raised bit, then pending bit) over the seven
// sources and gives one result per dispatch in source order; the sequencer
// waits whenever it has a result to give and the result register is still
// held by the sink. The last result of every item has last set.
// ----------------------------------------------------------------------------
module interrupt_mask_pending_dispatch_core import imdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    imdp_req_if.sink   request,
    imdp_rsp_if.source result
);

    push_t push;
    head_t head;
    logic  q_full;
    logic  pop;

    // request decode
    imdp_front u_front
    (
        .request (request),
        .q_full  (q_full),
        .push    (push)
    );

    // item queue
    imdp_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // mask state and dispatch sequencer
    imdp_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule : interrupt_mask_pending_dispatch_core
`default_nettype wire

@@ tb/interrupt_mask_pending_dispatch_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_mask_pending_dispatch_core_tb: self-checking bench for the core
// A queue of request items, directed cases first and then random traffic,
// feeds a clocked driver. A clocked monitor tracks the masks of every
// controller, predicts the dispatch results of each accepted request and
// checks each result field by field. Both sides idle at random, and the
// result side holds off once for a long stretch so the core backs up.
// ----------------------------------------------------------------------------
module interrupt_mask_pending_dispatch_core_tb;
    import imdp_pkg::*;

    // unused command codes, which change no state in the core
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam int RANDOM_TARGET    = 280;
    localparam int IDLE_PERCENT     = 34;
    localparam int STEADY_FIRST     = 140;
    localparam int STEADY_LAST      = 200;
    localparam int BACKUP_AFTER     = 60;
    localparam int BACKUP_CYCLES    = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int PRINT_LIMIT      = 50;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // stimulus side registers, known from time zero
    logic     req_valid = 1'b0;
    request_t req_data  = '0;
    logic     rsp_ready = 1'b0;

    imdp_req_if request ();
    imdp_rsp_if result ();

    assign request.valid = req_valid;
    assign request.data  = req_data;
    assign result.ready  = rsp_ready;

    interrupt_mask_pending_dispatch_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result)
    );

    // mask state of the predictor, zero after reset
    logic [SOURCES-1:0] disabled_mask [CONTROLLERS] = '{default: '0};
    logic [SOURCES-1:0] pending_mask  [CONTROLLERS] = '{default: '0};

    request_t pending_requests [$];
    result_t  expected_results [$];

    int   accepted_count = 0;
    int   error_count    = 0;
    int   stall_cycles   = 0;
    int   backup_left    = 0;
    logic backup_done    = 1'b0;
    logic steady;

    // window with no idling on either side
    assign steady = (accepted_count >= STEADY_FIRST) && (accepted_count < STEADY_LAST);

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    task automatic add_request(input logic [CMD_W-1:0] cmd, input int ctl, input int src,
                               input int ev);
        request_t req;
        req.cmd          = cmd;
        req.controller   = CTL_W'(ctl);
        req.source_index = SRC_W'(src);
        req.events       = EV_W'(ev);
        pending_requests.push_back(req);
    endtask

    function automatic result_t dispatch_result(input logic [CTL_W-1:0] ctl, input int src);
        result_t res;
        res                 = '0;
        res.dispatch_valid  = 1'b1;
        res.dispatch_source = SRC_W'(src);
        res.irq_number      = IRQ_W'((int'(ctl) + 1) * 8 + src);
        return res;
    endfunction

    // expected results of one request, masks updated in scan order
    task automatic predict_dispatch(input request_t req);
        logic [SOURCES-1:0] sel;
        logic [SOURCES-1:0] one;
        logic [CTL_W-1:0]   ctl;
        logic               pbit;
        int                 produced;
        result_t            res;
        ctl      = req.controller;
        sel      = (req.source_index < SOURCES) ? (SOURCES'(1) << req.source_index) : '0;
        pbit     = 1'b0;
        produced = 0;
        if (int'(ctl) < CONTROLLERS)
        begin
            case (req.cmd)
                CMD_EVENT:
                begin
                    if (req.events[SOURCES-1:0] == '0)
                    begin
                        res                 = '0;
                        res.nothing_pending = 1'b1;
                        expected_results.push_back(res);
                        produced++;
                    end
                    else
                    begin
                        for (int i = 0; i < SOURCES; i++)
                        begin
                            one = SOURCES'(1) << i;
                            // raised source: park it if disabled, else dispatch
                            if (req.events[i])
                            begin
                                if ((disabled_mask[ctl] & one) != '0)
                                begin
                                    pending_mask[ctl] |= one;
                                end
                                else
                                begin
                                    expected_results.push_back(dispatch_result(ctl, i));
                                    produced++;
                                end
                            end
                            // pending and enabled: dispatch again and clear
                            if (((pending_mask[ctl] & one) != '0) &&
                                ((disabled_mask[ctl] & one) == '0))
                            begin
                                expected_results.push_back(dispatch_result(ctl, i));
                                produced++;
                                pending_mask[ctl] &= ~one;
                            end
                        end
                    end
                end
                CMD_ENABLE:  disabled_mask[ctl] &= ~sel;
                CMD_DISABLE: disabled_mask[ctl] |= sel;
                CMD_CLEAR:   pending_mask[ctl]  &= ~sel;
                CMD_QUERY:   pbit = ((pending_mask[ctl] & sel) != '0);
                default:     ;
            endcase
        end
        if (produced == 0)
        begin
            res             = '0;
            res.pending_bit = pbit;
            expected_results.push_back(res);
        end
        res      = expected_results.pop_back();
        res.last = 1'b1;
        expected_results.push_back(res);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || request.ready)
        begin
            if ((pending_requests.size() != 0) &&
                (steady || ($urandom_range(99) >= IDLE_PERCENT)))
            begin
                req_valid <= 1'b1;
                req_data  <= pending_requests.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // result ready, with one long hold-off to back up the core
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (backup_left > 0)
        begin
            backup_left <= backup_left - 1;
            rsp_ready   <= 1'b0;
        end
        else if (!backup_done && (accepted_count >= BACKUP_AFTER))
        begin
            backup_left <= BACKUP_CYCLES;
            backup_done <= 1'b1;
            rsp_ready   <= 1'b0;
        end
        else
        begin
            rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // monitor: predict on request items, check result items
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                predict_dispatch(request.data);
                accepted_count <= accepted_count + 1;
            end
            if (result.valid && result.ready)
            begin
                got = result.data;
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result item with none expected: %h", got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.dispatch_valid !== want.dispatch_valid)
                        report_mismatch($sformatf("dispatch_valid got %0d want %0d",
                                                  got.dispatch_valid, want.dispatch_valid));
                    if (got.dispatch_source !== want.dispatch_source)
                        report_mismatch($sformatf("dispatch_source got %0d want %0d",
                                                  got.dispatch_source, want.dispatch_source));
                    if (got.irq_number !== want.irq_number)
                        report_mismatch($sformatf("irq_number got %0d want %0d",
                                                  got.irq_number, want.irq_number));
                    if (got.pending_bit !== want.pending_bit)
                        report_mismatch($sformatf("pending_bit got %0d want %0d",
                                                  got.pending_bit, want.pending_bit));
                    if (got.nothing_pending !== want.nothing_pending)
                        report_mismatch($sformatf("nothing_pending got %0d want %0d",
                                                  got.nothing_pending, want.nothing_pending));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last got %0d want %0d",
                                                  got.last, want.last));
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (result.valid && result.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus and end of run
    initial
    begin
        int ctl;
        int park_mask;
        int ev;
        // directed: query of reset state, full and empty event words
        add_request(CMD_QUERY, 0, 0, 0);
        add_request(CMD_EVENT, 0, 0, 7'h7F);
        add_request(CMD_EVENT, 7, 0, 7'h00);
        add_request(CMD_EVENT, 7, 0, 7'h40);
        // only disabled sources raised, out-of-range source ignored
        add_request(CMD_DISABLE, 1, 0, 0);
        add_request(CMD_DISABLE, 1, 6, 0);
        add_request(CMD_DISABLE, 1, 7, 0);
        add_request(CMD_EVENT, 1, 0, 7'h41);
        add_request(CMD_QUERY, 1, 0, 0);
        add_request(CMD_QUERY, 1, 6, 0);
        add_request(CMD_QUERY, 1, 7, 0);
        // enable does not dispatch; next event dispatches twice
        add_request(CMD_ENABLE, 1, 0, 0);
        add_request(CMD_EVENT, 1, 0, 7'h01);
        add_request(CMD_CLEAR, 1, 6, 0);
        add_request(CMD_QUERY, 1, 6, 0);
        // parked sources released together with a full event word
        add_request(CMD_DISABLE, 2, 3, 0);
        add_request(CMD_DISABLE, 2, 5, 0);
        add_request(CMD_EVENT, 2, 0, 7'h28);
        add_request(CMD_ENABLE, 2, 3, 0);
        add_request(CMD_ENABLE, 2, 5, 0);
        add_request(CMD_EVENT, 2, 0, 7'h7F);
        // unused command codes
        add_request(CMD_SPARE_FIRST, 3, 2, 7'h55);
        add_request(CMD_SPARE_LAST, 4, 5, 7'h2A);

        // random: mostly park-and-release sequences, the rest loose items
        while (pending_requests.size() < RANDOM_TARGET)
        begin
            if ($urandom_range(99) < 60)
            begin
                ctl       = $urandom_range(CONTROLLERS - 1);
                park_mask = $urandom_range(127);
                for (int i = 0; i < SOURCES; i++)
                begin
                    if (park_mask[i])
                        add_request(CMD_DISABLE, ctl, i, $urandom_range(127));
                end
                ev = ($urandom_range(3) == 0) ? 7'h7F : $urandom_range(127);
                add_request(CMD_EVENT, ctl, $urandom_range(7), ev);
                if ($urandom_range(1) == 1)
                    add_request(CMD_QUERY, ctl, $urandom_range(7), $urandom_range(127));
                if ($urandom_range(4) == 0)
                    add_request(CMD_CLEAR, ctl, $urandom_range(7), $urandom_range(127));
                for (int i = 0; i < SOURCES; i++)
                begin
                    if (park_mask[i] && ($urandom_range(3) != 0))
                        add_request(CMD_ENABLE, ctl, i, $urandom_range(127));
                end
                ev = ($urandom_range(2) == 0) ? 7'h7F : $urandom_range(127);
                add_request(CMD_EVENT, ctl, $urandom_range(7), ev);
            end
            else
            begin
                add_request(CMD_W'($urandom_range(7)), $urandom_range(7),
                            $urandom_range(7),
                            ($urandom_range(5) == 0) ? 0 : $urandom_range(127));
            end
        end

        // hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every request to go in and every result to come out
        while ((pending_requests.size() != 0) || req_valid || (expected_results.size() != 0))
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule : interrupt_mask_pending_dispatch_core_tb
